### rtl/bdq_pkg.sv
// bdq_pkg: shared types and codes for the bounded double-ended queue
// holds command, status, cell operation and sequencer state types
// no dependencies; used by bdq_cell and bounded_double_ended_queue
package bdq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 6;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_POP_FRONT  = 2'd1,
    CMD_PUSH_BACK  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD     = 3'd0,
    CELL_TO_BACK  = 3'd1,
    CELL_TO_FRONT = 3'd2,
    CELL_LOAD_AT  = 3'd3,
    CELL_TAKE_AT  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [WORD_W-1:0]   value;
  } cell_ctl_t;

  typedef enum logic [0:0] {
    ST_IDLE     = 1'b0,
    ST_POP_BACK = 1'b1
  } state_t;

endpackage

### rtl/bdq_cell.sv
// bdq_cell: one word slot of the deque chain plus a carry slot
// the carry slot moves a back word toward the front one cell per cycle
// depends on bdq_pkg
module bdq_cell #(
  parameter int unsigned SEL_W      = 6,
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bdq_pkg::cell_ctl_t          ctl,
  input  logic [SEL_W-1:0]            sel,
  input  logic [bdq_pkg::WORD_W-1:0]  prev_data,
  input  logic [bdq_pkg::WORD_W-1:0]  next_data,
  input  logic                        next_carry_valid,
  input  logic [bdq_pkg::WORD_W-1:0]  next_carry_data,
  output logic [bdq_pkg::WORD_W-1:0]  data,
  output logic                        carry_valid,
  output logic [bdq_pkg::WORD_W-1:0]  carry_data
);

  logic hit;

  assign hit = (sel == SEL_W'(CELL_INDEX));

  always_ff @(posedge clk) begin
    case (ctl.op)
      bdq_pkg::CELL_TO_BACK:  data <= prev_data;
      bdq_pkg::CELL_TO_FRONT: data <= next_data;
      bdq_pkg::CELL_LOAD_AT:  if (hit) begin
        data <= ctl.value;
      end
      default: data <= data;
    endcase
  end

  // carry slot: picked up at the hit cell, otherwise shifts toward the front
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_valid <= 1'b0;
    end else if (ctl.op == bdq_pkg::CELL_TAKE_AT && hit) begin
      carry_valid <= 1'b1;
    end else begin
      carry_valid <= next_carry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == bdq_pkg::CELL_TAKE_AT && hit) begin
      carry_data <= data;
    end else begin
      carry_data <= next_carry_data;
    end
  end

endmodule

### rtl/bounded_double_ended_queue.sv
// bounded_double_ended_queue: deque built as a row of DEPTH word cells, front at cell 0
// push, full/empty refusal and pop front give their result in the cycle after accept
// pop back (not empty): last word walks to cell 0 via the carry slot; input waits
// throughput: 1 transaction per cycle when idle and the result slot is free or draining
// reset: synchronous active-high rst empties the deque and sets capacity to 32
// depends on bdq_pkg and bdq_cell
module bounded_double_ended_queue #(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel: capacity
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,     // [5:0] capacity
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,      // [31:0] value
  input  logic [1:0]  s_tuser,      // [1:0] command
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,      // [31:0] popped_value, [37:32] occupancy, [39:38] zero
  output logic [1:0]  m_tuser       // [1:0] status
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > bdq_pkg::CAP_W) ? CNT_W : bdq_pkg::CAP_W;
  localparam int unsigned WW    = bdq_pkg::WORD_W;

  // control state
  bdq_pkg::state_t  state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [5:0]       capacity;

  // result register
  bdq_pkg::status_t out_status, status_reg;
  logic [WW-1:0]    out_popped, popped_reg;
  logic [5:0]       occ_reg;
  logic             out_load;

  // chain wiring
  bdq_pkg::cell_ctl_t cell_ctl;
  logic [CNT_W-1:0]   cell_sel;
  logic [WW-1:0]      cell_data  [DEPTH];
  logic               carry_valid_w [DEPTH];
  logic [WW-1:0]      carry_data [DEPTH];
  logic [DEPTH-1:0]   carry_vec;

  bdq_pkg::cmd_t cmd;
  logic          in_fire;
  logic          full;
  logic          empty;

  assign cmd       = bdq_pkg::cmd_t'(s_tuser);
  assign s_tready  = (state == bdq_pkg::ST_IDLE) && (!m_tvalid || m_tready);
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // capacity above DEPTH is clamped: the store itself being full covers that case
  assign full  = (count == CNT_W'(DEPTH)) || (CMP_W'(count) >= CMP_W'(capacity));
  assign empty = (count == '0);

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bdq_pkg::ST_IDLE: begin
        if (in_fire && cmd == bdq_pkg::CMD_POP_BACK && !empty) begin
          state_next = bdq_pkg::ST_POP_BACK;
        end
      end
      bdq_pkg::ST_POP_BACK: begin
        if (carry_valid_w[0]) begin
          state_next = bdq_pkg::ST_IDLE;
        end
      end
      default: state_next = bdq_pkg::ST_IDLE;
    endcase
  end

  // outputs: cell commands, count update and result load
  always_comb begin
    cell_ctl.op    = bdq_pkg::CELL_HOLD;
    cell_ctl.value = s_tdata;
    cell_sel       = '0;
    count_next     = count;
    out_load       = 1'b0;
    out_status     = bdq_pkg::STATUS_DONE;
    out_popped     = '0;
    unique case (state)
      bdq_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            bdq_pkg::CMD_PUSH_FRONT: begin
              out_load = 1'b1;
              if (full) begin
                out_status = bdq_pkg::STATUS_FULL;
              end else begin
                // whole row moves one cell back, new word enters cell 0
                cell_ctl.op = bdq_pkg::CELL_TO_BACK;
                count_next  = count + CNT_W'(1);
              end
            end
            bdq_pkg::CMD_PUSH_BACK: begin
              out_load = 1'b1;
              if (full) begin
                out_status = bdq_pkg::STATUS_FULL;
              end else begin
                cell_ctl.op = bdq_pkg::CELL_LOAD_AT;
                cell_sel    = count;
                count_next  = count + CNT_W'(1);
              end
            end
            bdq_pkg::CMD_POP_FRONT: begin
              out_load = 1'b1;
              if (empty) begin
                out_status = bdq_pkg::STATUS_EMPTY;
              end else begin
                out_popped  = cell_data[0];
                cell_ctl.op = bdq_pkg::CELL_TO_FRONT;
                count_next  = count - CNT_W'(1);
              end
            end
            bdq_pkg::CMD_POP_BACK: begin
              if (empty) begin
                out_load   = 1'b1;
                out_status = bdq_pkg::STATUS_EMPTY;
              end else begin
                // last word goes into the carry slot and walks to cell 0
                cell_ctl.op = bdq_pkg::CELL_TAKE_AT;
                cell_sel    = count - CNT_W'(1);
                count_next  = count - CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      bdq_pkg::ST_POP_BACK: begin
        if (carry_valid_w[0]) begin
          out_load   = 1'b1;
          out_popped = carry_data[0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdq_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // result register: a fresh result only loads when the slot is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_reg <= out_status;
      popped_reg <= out_popped;
      occ_reg    <= 6'(count_next);
    end
  end

  assign m_tuser = status_reg;
  assign m_tdata = {2'b00, occ_reg, popped_reg};

  // row of cells, cell 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WW-1:0] prev_w;
    logic [WW-1:0] next_w;
    logic          next_cv_w;
    logic [WW-1:0] next_cd_w;

    if (i == 0) begin : g_first
      assign prev_w = s_tdata;
    end else begin : g_mid
      assign prev_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_w    = '0;
      assign next_cv_w = 1'b0;
      assign next_cd_w = '0;
    end else begin : g_inner
      assign next_w    = cell_data[i+1];
      assign next_cv_w = carry_valid_w[i+1];
      assign next_cd_w = carry_data[i+1];
    end

    bdq_cell #(
      .SEL_W      (CNT_W),
      .CELL_INDEX (i)
    ) u_cell (
      .clk              (clk),
      .rst              (rst),
      .ctl              (cell_ctl),
      .sel              (cell_sel),
      .prev_data        (prev_w),
      .next_data        (next_w),
      .next_carry_valid (next_cv_w),
      .next_carry_data  (next_cd_w),
      .data             (cell_data[i]),
      .carry_valid      (carry_valid_w[i]),
      .carry_data       (carry_data[i])
    );

    assign carry_vec[i] = carry_valid_w[i];
  end

`ifndef SYNTHESIS
  // occupancy never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  // no more than one word in flight on the carry path
  a_one_carry: assert property (@(posedge clk) disable iff (rst)
    $onehot0(carry_vec))
    else $error("more than one carry in flight");

  // a carry only reaches the front while a pop back is pending
  a_carry_state: assert property (@(posedge clk) disable iff (rst)
    carry_valid_w[0] |-> state == bdq_pkg::ST_POP_BACK)
    else $error("carry at front outside pop back");

  // an accepted push with room raises the count by one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !full && (cmd == bdq_pkg::CMD_PUSH_FRONT || cmd == bdq_pkg::CMD_PUSH_BACK))
    |=> count == $past(count) + CNT_W'(1))
    else $error("push did not raise count");

  // a pop back with words held blocks the next command while the carry walks
  a_popback_wait: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !empty && cmd == bdq_pkg::CMD_POP_BACK) |=> !s_tready)
    else $error("input taken while pop back pending");
`endif

endmodule

### dv/bounded_double_ended_queue_tb.sv
`timescale 1ns / 1ps
// bounded_double_ended_queue_tb: self-checking testbench for the bounded deque
// drives random and directed commands, predicts every result and checks it field by field
// depends on bdq_pkg and the bounded_double_ended_queue rtl
module bounded_double_ended_queue_tb;

  localparam int DEPTH       = 32;
  localparam int STALL_LIMIT = 2000;   // cycles with no transaction at all before giving up

  // one command as it travels on the slave stream
  typedef struct {
    bdq_pkg::cmd_t cmd;
    logic [31:0]   value;
  } deque_cmd_t;

  // one result as the master stream should carry it
  typedef struct {
    bdq_pkg::status_t status;
    logic [31:0]      popped;
    logic [5:0]       occupancy;
  } deque_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;         // [31:0] value
  logic [1:0]  s_tuser = '0;         // [1:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;              // [31:0] popped_value, [37:32] occupancy, [39:38] zero
  logic [1:0]  m_tuser;              // [1:0] status

  bounded_double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // commands waiting for the driver, results waiting for the block
  deque_cmd_t   command_backlog[$];
  deque_reply_t predicted_replies[$];

  // shadow copy of the deque: circular store, front index, word count, capacity register
  logic [31:0] shadow_words [DEPTH];
  int          shadow_head     = 0;
  int          shadow_fill     = 0;
  int          shadow_capacity = 32;

  // run statistics and failure count
  int mismatches   = 0;
  int n_pushes     = 0;
  int n_pops       = 0;
  int n_full       = 0;
  int n_empty      = 0;
  int n_cap_writes = 0;
  int peak_fill    = 0;

  // when set, neither side inserts any gap
  bit no_gaps = 1'b0;

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // word values lean toward the extremes now and then
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // apply one accepted command to the shadow deque and queue the result it must give
  function automatic void apply_to_shadow(bdq_pkg::cmd_t cmd, logic [31:0] value);
    deque_reply_t reply;
    int           limit;
    int           slot;
    // capacity above the store depth is clamped
    limit        = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
    reply.status = bdq_pkg::STATUS_DONE;
    reply.popped = '0;
    case (cmd)
      bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
        // a lowered capacity keeps old words, so compare with >= not ==
        if (shadow_fill >= limit) begin
          reply.status = bdq_pkg::STATUS_FULL;
          n_full++;
        end else begin
          if (cmd == bdq_pkg::CMD_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            slot        = shadow_head;
          end else begin
            slot = (shadow_head + shadow_fill) % DEPTH;
          end
          shadow_words[slot] = value;
          shadow_fill++;
          n_pushes++;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          // empty pop returns zero, head stays where it is
          reply.status = bdq_pkg::STATUS_EMPTY;
          n_empty++;
        end else begin
          if (cmd == bdq_pkg::CMD_POP_FRONT) begin
            reply.popped = shadow_words[shadow_head];
            shadow_head  = (shadow_head + 1) % DEPTH;
          end else begin
            reply.popped = shadow_words[(shadow_head + shadow_fill - 1) % DEPTH];
          end
          shadow_fill--;
          n_pops++;
        end
      end
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    reply.occupancy = shadow_fill[5:0];
    predicted_replies.push_back(reply);
  endfunction

  // driver: presents backlog commands, records each accepted one in the shadow deque
  int send_gap = 0;
  always @(posedge clk) begin
    deque_cmd_t next_cmd;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_to_shadow(bdq_pkg::cmd_t'(s_tuser), s_tdata);
      end
      // the slot is free once the current command is taken or nothing is shown
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (command_backlog.size() != 0) begin
          next_cmd = command_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_cmd.value;
          s_tuser  <= next_cmd.cmd;
          send_gap = idle_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, each result transaction checked against the oldest prediction
  int stall_left = 0;
  always @(posedge clk) begin
    deque_reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_replies.size() == 0) begin
          $error("result transaction with no command outstanding");
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            mismatches++;
          end
          if (m_tdata[31:0] !== want.popped) begin
            $error("popped_value: expected %0d, got %0d",
                   $signed(want.popped), $signed(m_tdata[31:0]));
            mismatches++;
          end
          if (m_tdata[37:32] !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, m_tdata[37:32]);
            mismatches++;
          end
          if (m_tdata[39:38] !== 2'b00) begin
            $error("tdata pad: expected 0, got %0d", m_tdata[39:38]);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = idle_gap();
      end
    end
  end

  // watchdog: any transaction on any channel restarts the count
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("bounded_double_ended_queue regression: fail");
    $finish;
  end

  task automatic add_cmd(input bdq_pkg::cmd_t cmd, input logic [31:0] value);
    command_backlog.push_back('{cmd, value});
  endtask

  // idle means every command sent and every result back; checked between edges
  task automatic wait_until_drained();
    @(negedge clk);
    while (command_backlog.size() != 0 || s_tvalid || predicted_replies.size() != 0)
      @(negedge clk);
  endtask

  // capacity is only rewritten while the deque has nothing in flight
  task automatic write_capacity(input logic [5:0] cap);
    wait_until_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_capacity = cap;
    n_cap_writes++;
    @(negedge clk);
  endtask

  // random walk over the deque, push bias changed every couple dozen commands so
  // the fill level swings between empty and full
  task automatic queue_random_run(input int count);
    int            push_pct;
    bdq_pkg::cmd_t cmd;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      if ($urandom_range(0, 99) < push_pct)
        cmd = $urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT;
      else
        cmd = $urandom_range(0, 1) ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_POP_FRONT;
      add_cmd(cmd, pick_word());
    end
  endtask

  // capacity settings for the random part: reset value, clamped top, tiny, zero, odd sizes
  logic [5:0] capacity_plan [12] = '{6'd32, 6'd63, 6'd1, 6'd2, 6'd8, 6'd33,
                                     6'd0, 6'd17, 6'd31, 6'd32, 6'd0, 6'd0};

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty deque refuses both pops
    add_cmd(bdq_pkg::CMD_POP_FRONT, 32'hFFFF_FFFF);
    add_cmd(bdq_pkg::CMD_POP_BACK, 32'h1234_5678);
    // front push from head 0 wraps to the top of the store
    add_cmd(bdq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    add_cmd(bdq_pkg::CMD_PUSH_BACK, 32'h8000_0000);
    add_cmd(bdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    add_cmd(bdq_pkg::CMD_PUSH_BACK, 32'h0000_0000);
    add_cmd(bdq_pkg::CMD_POP_BACK, '0);
    add_cmd(bdq_pkg::CMD_POP_FRONT, '0);
    add_cmd(bdq_pkg::CMD_POP_FRONT, '0);
    add_cmd(bdq_pkg::CMD_POP_BACK, '0);
    // deque now empty with head left where it was
    add_cmd(bdq_pkg::CMD_PUSH_BACK, 32'd1);
    add_cmd(bdq_pkg::CMD_PUSH_BACK, 32'd2);
    add_cmd(bdq_pkg::CMD_PUSH_BACK, 32'd3);
    // capacity dropped below the count: words kept, pushes refused until pops make room
    write_capacity(6'd2);
    add_cmd(bdq_pkg::CMD_PUSH_FRONT, 32'd4);
    add_cmd(bdq_pkg::CMD_POP_FRONT, '0);
    add_cmd(bdq_pkg::CMD_POP_FRONT, '0);
    add_cmd(bdq_pkg::CMD_PUSH_BACK, 32'd5);
    // zero capacity: every push full, held words still pop
    write_capacity(6'd0);
    add_cmd(bdq_pkg::CMD_PUSH_BACK, 32'd6);
    add_cmd(bdq_pkg::CMD_POP_BACK, '0);
    add_cmd(bdq_pkg::CMD_POP_FRONT, '0);
    add_cmd(bdq_pkg::CMD_POP_FRONT, '0);
    add_cmd(bdq_pkg::CMD_PUSH_FRONT, 32'd7);

    // random part, one run per capacity setting
    capacity_plan[10] = $urandom_range(1, 63);
    capacity_plan[11] = $urandom_range(1, 63);
    foreach (capacity_plan[p]) begin
      write_capacity(capacity_plan[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      queue_random_run((capacity_plan[p] == 0) ? 30 : 155);
    end

    wait_until_drained();
    repeat (DEPTH + 8) @(posedge clk);
    if (predicted_replies.size() != 0) begin
      $error("%0d results never arrived", predicted_replies.size());
      mismatches++;
    end

    $display("covered %0d pushes, %0d pops, %0d full refusals, %0d empty refusals",
             n_pushes, n_pops, n_full, n_empty);
    $display("over %0d capacity writes, peak occupancy %0d, %0d mismatches",
             n_cap_writes, peak_fill, mismatches);
    if (mismatches == 0)
      $display("bounded_double_ended_queue regression: pass");
    else
      $display("bounded_double_ended_queue regression: fail");
    $finish;
  end

endmodule

### sim.f
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bounded_double_ended_queue.sv
dv/bounded_double_ended_queue_tb.sv
